@@ rtl/h2dfr_pkg.sv @@
// Package: shared types and constants for the HTTP/2 frame deframer.
package h2dfr_pkg;

   localparam int unsigned H2DFR_QUEUE_DEPTH = 4;
   localparam logic [23:0] H2DFR_MAX_FRAME_RESET = 24'd16384;
   localparam logic [3:0]  H2DFR_LAST_HDR_BYTE = 4'd8;
   localparam int unsigned H2DFR_TDATA_W = 80;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_HEADER,
      ST_PAYLOAD,
      ST_HALTED
   } front_state_type;

   typedef struct packed {
      kind_type    kind;
      logic [23:0] frame_length;
      logic [7:0]  frame_type;
      logic [7:0]  frame_flags;
      logic [30:0] stream_number;
      logic [7:0]  payload_byte;
      logic        last;
   } result_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ rtl/h2dfr_front.sv @@
// Front end: header assembly, frame classification and payload counting.
module h2dfr_front
   import h2dfr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,
   input  logic             csr_we,
   input  logic [23:0]      csr_wdata,
   input  queue_status_type q_status,
   output logic             push,
   output result_type       push_data
);

   front_state_type state_ff, state_in;
   logic [3:0]  hdr_count_ff, hdr_count_in;
   logic [23:0] length_ff, length_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  flags_ff, flags_in;
   logic [30:0] stream_ff, stream_in;
   logic [23:0] left_ff, left_in;
   logic [23:0] max_ff;

   logic accept;
   logic hdr_done;
   logic oversize;
   logic zero_len;
   logic pay_last;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;

   // header field capture, big-endian
   always_comb begin
      length_in = length_ff;
      type_in   = type_ff;
      flags_in  = flags_ff;
      stream_in = stream_ff;
      if (state_ff == ST_HEADER) begin
         if (hdr_count_ff < 4'd3) begin
            length_in = {length_ff[15:0], req_tdata};
         end else if (hdr_count_ff == 4'd3) begin
            type_in = req_tdata;
         end else if (hdr_count_ff == 4'd4) begin
            flags_in = req_tdata;
         end else begin
            stream_in = {stream_ff[22:0], req_tdata};
         end
      end
   end

   assign hdr_done = (state_ff == ST_HEADER) && (hdr_count_ff == H2DFR_LAST_HDR_BYTE);
   assign oversize = length_in > max_ff;
   assign zero_len = length_in == 24'd0;
   assign pay_last = left_ff == 24'd1;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_HEADER: begin
            if (accept && hdr_done) begin
               if (oversize) begin
                  state_in = ST_HALTED;
               end else if (!zero_len) begin
                  state_in = ST_PAYLOAD;
               end
            end
         end
         ST_PAYLOAD: begin
            if (accept && pay_last) begin
               state_in = ST_HEADER;
            end
         end
         ST_HALTED: state_in = ST_HALTED;
         default:   state_in = ST_HEADER;
      endcase
   end

   always_comb begin
      push                    = 1'b0;
      push_data.kind          = KIND_HEADER;
      push_data.frame_length  = length_in;
      push_data.frame_type    = type_in;
      push_data.frame_flags   = flags_in;
      push_data.stream_number = stream_in;
      push_data.payload_byte  = 8'd0;
      push_data.last          = 1'b0;
      hdr_count_in            = hdr_count_ff;
      left_in                 = left_ff;
      unique case (state_ff)
         ST_HEADER: begin
            if (accept) begin
               if (hdr_done) begin
                  push           = 1'b1;
                  hdr_count_in   = 4'd0;
                  left_in        = length_in;
                  push_data.kind = oversize ? KIND_ERROR : KIND_HEADER;
                  push_data.last = oversize || zero_len;
               end else begin
                  hdr_count_in = hdr_count_ff + 4'd1;
               end
            end
         end
         ST_PAYLOAD: begin
            if (accept) begin
               push                   = 1'b1;
               left_in                = left_ff - 24'd1;
               push_data.kind         = KIND_PAYLOAD;
               push_data.payload_byte = req_tdata;
               push_data.last         = pay_last;
            end
         end
         ST_HALTED: push = 1'b0;
         default:   push = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_HEADER;
         hdr_count_ff <= 4'd0;
         length_ff    <= 24'd0;
         type_ff      <= 8'd0;
         flags_ff     <= 8'd0;
         stream_ff    <= 31'd0;
         left_ff      <= 24'd0;
         max_ff       <= H2DFR_MAX_FRAME_RESET;
      end else begin
         if (csr_we) begin
            max_ff <= csr_wdata;
         end
         if (accept) begin
            state_ff     <= state_in;
            hdr_count_ff <= hdr_count_in;
            length_ff    <= length_in;
            type_ff      <= type_in;
            flags_ff     <= flags_in;
            stream_ff    <= stream_in;
            left_ff      <= left_in;
         end
      end
   end

`ifndef SYNTH
   a_push_needs_accept: assert property (@(posedge clock) disable iff (reset)
      push |-> accept)
      else $error("push without accepted item");
   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PAYLOAD |-> left_ff != 24'd0)
      else $error("payload state with no bytes left");
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_HALTED |=> state_ff == ST_HALTED)
      else $error("left halted state without reset");
   a_hdr_range: assert property (@(posedge clock) disable iff (reset)
      hdr_count_ff <= H2DFR_LAST_HDR_BYTE)
      else $error("header byte count out of range");
`endif

endmodule

@@ rtl/h2dfr_queue.sv @@
// Queue: small result FIFO between front end and output stage.
module h2dfr_queue
   import h2dfr_pkg::*;
#(
   parameter int unsigned DEPTH = H2DFR_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  result_type       push_data,
   input  logic             pop,
   output result_type       pop_data,
   output queue_status_type status
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   result_type       entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.full  = count_ff == CNT_FULL;
   assign status.empty = count_ff == '0;
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && status.full))
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && status.empty))
      else $error("pop from empty queue");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not follow push");
`endif

endmodule

@@ rtl/h2dfr_back.sv @@
// Output stage: drains the queue into the registered result channel.
module h2dfr_back
   import h2dfr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  queue_status_type         q_status,
   input  result_type               q_data,
   output logic                     pop,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [H2DFR_TDATA_W-1:0] rsp_tdata,
   output logic [1:0]               rsp_tuser,
   output logic                     rsp_tlast
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign pop      = !q_status.empty && (!valid_ff || rsp_tready);
   assign valid_in = pop || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= q_data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = data_ff.kind;
   assign rsp_tlast  = data_ff.last;
   assign rsp_tdata  = {1'b0, data_ff.payload_byte, data_ff.stream_number,
                        data_ff.frame_flags, data_ff.frame_type, data_ff.frame_length};

endmodule

@@ rtl/http2_frame_deframer_top.sv @@
// A result is written into the result queue when its byte is accepted and then moved into the rsp output register.
// Throughput: one byte per cycle; req_tready drops only when the result queue is full.
// The result queue holds QUEUE_DEPTH items between the parser and the output register.
// Reset (synchronous, active high) clears the parser, the queue and the output valid,
// and sets the frame size limit to 16384; a halted block resumes only through reset.
module http2_frame_deframer_top
   import h2dfr_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = H2DFR_QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,   // [7:0] in_byte
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [23:0] frame_length, [31:24] frame_type, [39:32] frame_flags,
   // [70:40] stream_number, [78:71] payload_byte, [79] zero
   output logic [H2DFR_TDATA_W-1:0] rsp_tdata,
   output logic [1:0]               rsp_tuser,   // [1:0] kind
   output logic                     rsp_tlast,
   input  logic                     csr_we,
   input  logic [23:0]              csr_wdata    // frame size limit
);

   queue_status_type q_status;
   logic             push;
   logic             pop;
   result_type       push_data;
   result_type       pop_data;

   h2dfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .q_status   (q_status),
      .push       (push),
      .push_data  (push_data)
   );

   h2dfr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   h2dfr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_data     (pop_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ verif/http2_frame_deframer_top_test.sv @@
// Testbench for the HTTP/2 frame deframer: byte streams in, checked header/payload/error items out.
`timescale 1ns / 100ps

module http2_frame_deframer_top_test;
   import h2dfr_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 5;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [H2DFR_TDATA_W-1:0] rsp_tdata;
   logic [1:0]        rsp_tuser;
   logic              rsp_tlast;
   logic              csr_we = 1'b0;
   logic [23:0]       csr_wdata = '0;

   http2_frame_deframer_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   logic [7:0] byte_queue[$];
   result_type expected_results[$];

   int send_idle_pct = 25;
   int recv_idle_pct = 80;
   int hold_requests = 0;
   int hold_served = 0;
   int hold_left = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int bytes_queued = 0;
   int frames_queued = 0;
   int headers_seen = 0;
   int payloads_seen = 0;
   int errors_seen = 0;

   // parser shadow state
   logic [23:0] frame_limit = H2DFR_MAX_FRAME_RESET;
   logic [3:0]  hdr_count = '0;
   logic [23:0] cur_length = '0;
   logic [7:0]  cur_type = '0;
   logic [7:0]  cur_flags = '0;
   logic [30:0] cur_stream = '0;
   logic [23:0] payload_left = '0;
   logic        in_payload = 1'b0;
   logic        parser_halted = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic result_type frame_result(kind_type k, logic [7:0] pbyte, logic last_flag);
      result_type r;
      r.kind = k;
      r.frame_length = cur_length;
      r.frame_type = cur_type;
      r.frame_flags = cur_flags;
      r.stream_number = cur_stream;
      r.payload_byte = pbyte;
      r.last = last_flag;
      return r;
   endfunction

   function automatic string describe(result_type r);
      return $sformatf("kind=%0d len=%0d type=%0d flags=%0d stream=%0d byte=%0d last=%0d",
                       r.kind, r.frame_length, r.frame_type, r.frame_flags,
                       r.stream_number, r.payload_byte, r.last);
   endfunction

   task automatic add_expected(input result_type r);
      expected_results = {expected_results, r};
   endtask

   task automatic parse_byte(input logic [7:0] b);
      if (parser_halted) return;
      if (in_payload) begin
         payload_left = payload_left - 24'd1;
         add_expected(frame_result(KIND_PAYLOAD, b, payload_left == '0));
         if (payload_left == '0) begin
            in_payload = 1'b0;
            hdr_count = '0;
         end
         return;
      end
      case (hdr_count)
         4'd0, 4'd1, 4'd2: cur_length = {cur_length[15:0], b};
         4'd3: cur_type = b;
         4'd4: cur_flags = b;
         default: cur_stream = {cur_stream[22:0], b};
      endcase
      if (hdr_count != H2DFR_LAST_HDR_BYTE) begin
         hdr_count = hdr_count + 4'd1;
         return;
      end
      hdr_count = '0;
      if (cur_length > frame_limit) begin
         parser_halted = 1'b1;
         add_expected(frame_result(KIND_ERROR, 8'd0, 1'b1));
      end else if (cur_length == '0) begin
         add_expected(frame_result(KIND_HEADER, 8'd0, 1'b1));
      end else begin
         payload_left = cur_length;
         in_payload = 1'b1;
         add_expected(frame_result(KIND_HEADER, 8'd0, 1'b0));
      end
   endtask

   // byte sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            parse_byte(req_tdata);
         end
         if (!req_tvalid || req_tready) begin
            if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= byte_queue.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result receiver and checker
   always @(posedge clock) begin
      result_type got;
      result_type exp;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind = kind_type'(rsp_tuser);
            got.frame_length = rsp_tdata[23:0];
            got.frame_type = rsp_tdata[31:24];
            got.frame_flags = rsp_tdata[39:32];
            got.stream_number = rsp_tdata[70:40];
            got.payload_byte = rsp_tdata[78:71];
            got.last = rsp_tlast;
            case (got.kind)
               KIND_HEADER: headers_seen++;
               KIND_PAYLOAD: payloads_seen++;
               default: errors_seen++;
            endcase
            if (expected_results.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected item, expected none, actual %s", $time, describe(got));
            end else begin
               exp = expected_results.pop_front();
               if (got !== exp) begin
                  mismatch_count++;
                  $display("%0t: mismatch, expected %s, actual %s",
                           $time, describe(exp), describe(got));
               end
            end
         end
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (hold_served != hold_requests) begin
            hold_served <= hold_served + 1;
            hold_left <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d items outstanding", $time, expected_results.size());
         $display("[http2_frame_deframer_top] ERROR");
         $finish;
      end
   end

   task automatic queue_byte(input logic [7:0] b);
      byte_queue = {byte_queue, b};
      bytes_queued++;
   endtask

   task automatic queue_frame(input logic [23:0] len, input logic [7:0] ftype,
                              input logic [7:0] flags, input logic [31:0] sid);
      queue_byte(len[23:16]);
      queue_byte(len[15:8]);
      queue_byte(len[7:0]);
      queue_byte(ftype);
      queue_byte(flags);
      queue_byte(sid[31:24]);
      queue_byte(sid[23:16]);
      queue_byte(sid[15:8]);
      queue_byte(sid[7:0]);
      for (int i = 0; i < len; i++) queue_byte(8'($urandom_range(255)));
      frames_queued++;
   endtask

   task automatic queue_random_frames(input int byte_budget, input int cap);
      int start;
      int len;
      int pick;
      logic [7:0] ftype;
      start = bytes_queued;
      while (bytes_queued - start < byte_budget) begin
         pick = $urandom_range(99);
         if (pick < 20) len = 0;
         else if (pick < 70) len = $urandom_range(1, 8);
         else if (pick < 95) len = $urandom_range(9, 40);
         else len = cap;
         if (len > cap) len = cap;
         ftype = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(9));
         queue_frame(24'(len), ftype, 8'($urandom_range(255)), $urandom);
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (byte_queue.size() != 0 || req_tvalid || expected_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_frame_limit(input logic [23:0] limit);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= limit;
      @(posedge clock);
      csr_we <= 1'b0;
      frame_limit = limit;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset limit, header field extremes, zero-length and short frames
      queue_frame(24'd0, 8'h00, 8'h00, 32'h0000_0000);
      queue_frame(24'd0, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
      queue_frame(24'd1, 8'h00, 8'h01, 32'h8000_0001);
      queue_frame(24'd2, 8'h01, 8'h04, 32'h7FFF_FFFF);
      queue_random_frames(130, 40);
      wait_drained();

      send_idle_pct = 80;
      recv_idle_pct = 25;
      write_frame_limit(24'hFF_FFFF);
      queue_random_frames(130, 40);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_frame_limit(24'd16384);
      hold_requests = hold_requests + 1;
      queue_random_frames(110, 40);
      wait_drained();

      // limit below the nominal range; exact limit passes, one more halts the parser
      write_frame_limit(24'd40);
      queue_frame(24'd40, 8'h00, 8'h00, 32'h0000_0003);
      queue_random_frames(60, 40);
      queue_frame(24'd41, 8'h01, 8'h00, 32'h0000_0005);
      queue_random_frames(25, 40);
      wait_drained();
      repeat (20) @(posedge clock);

      $display("Covered %0d bytes in %0d frames over four limit settings, stalls on both sides.",
               bytes_queued, frames_queued);
      $display("Checked %0d headers, %0d payload bytes, %0d oversize errors; %0d mismatches.",
               headers_seen, payloads_seen, errors_seen, mismatch_count);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("[http2_frame_deframer_top] OK");
      end else begin
         $display("[http2_frame_deframer_top] ERROR");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/h2dfr_pkg.sv
rtl/h2dfr_front.sv
rtl/h2dfr_queue.sv
rtl/h2dfr_back.sv
rtl/http2_frame_deframer_top.sv
verif/http2_frame_deframer_top_test.sv
